@@ design/assert_macros.svh @@
// assertion helpers used by the checker file gapi_checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on the rising edge, ignored while reset is high
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// implication checked on the rising edge, ignored while reset is high
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

@@ design/gapi_pkg.sv @@
// ----------------------------------------------------------------------------
// gapi_pkg
// types, codes and constants of the video gate array palette/irq block
// ----------------------------------------------------------------------------
package gapi_pkg;

  localparam int PEN_W        = 5;
  localparam int COLOUR_W     = 5;
  localparam int PALETTE_SIZE = 17;
  localparam int LINE_CNT_W   = 6;
  localparam int PIX_IDX_W    = 3;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [PEN_W-1:0]      BORDER_PEN    = 5'd16;
  localparam logic [LINE_CNT_W-1:0] LINES_PER_IRQ = 6'd52;

  // command codes
  localparam logic [1:0] CMD_REG_WRITE  = 2'd0;
  localparam logic [1:0] CMD_LINE_END   = 2'd1;
  localparam logic [1:0] CMD_IRQ_ACK    = 2'd2;
  localparam logic [1:0] CMD_VIDEO_BYTE = 2'd3;

  // register write functions, data bits 7..6
  localparam logic [1:0] FN_PEN_SELECT = 2'd0;
  localparam logic [1:0] FN_COLOUR     = 2'd1;
  localparam logic [1:0] FN_MODE_ROM   = 2'd2;

  // video modes
  localparam logic [1:0] MODE_0 = 2'd0;
  localparam logic [1:0] MODE_1 = 2'd1;
  localparam logic [1:0] MODE_2 = 2'd2;
  localparam logic [1:0] MODE_3 = 2'd3;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] data;
    logic       vsync_line;
  } cmd_item_t;

  typedef struct packed {
    logic [PEN_W-1:0]    pen_index;
    logic [COLOUR_W-1:0] colour;
    logic                pixel_valid;
    logic                irq_pending;
    logic                rom_low_on;
    logic                rom_high_on;
    logic                rom_changed;
    logic [1:0]          active_mode;
    logic                last;
  } res_item_t;

  // classified work handed from front to back
  typedef struct packed {
    logic       is_pixel;
    logic [7:0] data;
    logic [1:0] mode;
    logic       irq;
    logic       rom_lo;
    logic       rom_hi;
    logic       rom_changed;
  } job_t;

  typedef logic [PALETTE_SIZE-1:0][COLOUR_W-1:0] palette_t;

endpackage

@@ design/video_gate_array_palette_irq_core.sv @@
// ----------------------------------------------------------------------------
// video_gate_array_palette_irq_core
// palette, video mode, rom enables and 52-line raster interrupt of a video
// gate array, with video bytes unpacked into pixels
// ----------------------------------------------------------------------------
// an accepted transaction enters the job queue, then the back end's output register
// throughput: one result per cycle from the back end's pixel counter unless stalled;
// a status command gives 1 result, a video byte 2, 4 or 8 (modes 0/3, 1, 2)
// a colour write is held off until the job queue has drained
// reset: synchronous, sets all control state (lower rom on, upper rom off, palette 0)
module video_gate_array_palette_irq_core
  import gapi_pkg::*;
#(
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  input  cmd_item_t cmd,
  output logic      res_valid,
  input  logic      res_ready,
  output res_item_t res
);

  // front to queue
  logic     push;
  job_t     push_job;
  logic     q_full;
  logic     q_busy;
  // queue to back
  job_t     head;
  logic     pop;
  // live palette, read by the back end at pixel emission
  palette_t palette;

  // front end: takes each transaction and applies its register effects at once
  gapi_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .q_full    (q_full),
    .q_busy    (q_busy),
    .push      (push),
    .job       (push_job),
    .palette   (palette)
  );

  // job queue decouples command intake from pixel expansion
  gapi_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .full     (q_full),
    .busy     (q_busy),
    .head     (head)
  );

  // back end: one result per cycle into the output register unless it is stalled
  gapi_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_busy),
    .head      (head),
    .palette   (palette),
    .pop       (pop),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule

@@ design/gapi_front.sv @@
// ----------------------------------------------------------------------------
// gapi_front
// accepts commands, updates pen select, mode, rom, palette, line counter and irq state
// ----------------------------------------------------------------------------
module gapi_front
  import gapi_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  input  cmd_item_t cmd,
  input  logic      q_full,
  input  logic      q_busy,
  output logic      push,
  output job_t      job,
  output palette_t  palette
);

  logic [PEN_W-1:0]      selected_pen, selected_pen_next;
  logic [1:0]            pending_mode, pending_mode_next;
  logic [1:0]            current_mode, current_mode_next;
  logic [LINE_CNT_W-1:0] line_counter, line_counter_next;
  logic [LINE_CNT_W-1:0] line_inc;
  logic                  irq_flag, irq_flag_next;
  logic                  low_rom, low_rom_next;
  logic                  high_rom, high_rom_next;
  logic                  changed;
  logic                  palette_we;
  logic                  is_colour_write;

  // colour writes wait until queued pixels have taken their colours
  assign is_colour_write = (cmd.command == CMD_REG_WRITE) && (cmd.data[7:6] == FN_COLOUR);
  assign cmd_ready = !q_full && !(is_colour_write && q_busy);
  assign push      = cmd_valid && cmd_ready;
  assign line_inc  = line_counter + 6'd1;

  always_comb begin
    selected_pen_next = selected_pen;
    pending_mode_next = pending_mode;
    current_mode_next = current_mode;
    line_counter_next = line_counter;
    irq_flag_next     = irq_flag;
    low_rom_next      = low_rom;
    high_rom_next     = high_rom;
    changed           = 1'b0;
    palette_we        = 1'b0;
    case (cmd.command)
      CMD_REG_WRITE: begin
        case (cmd.data[7:6])
          FN_PEN_SELECT: begin
            selected_pen_next = cmd.data[4] ? BORDER_PEN : {1'b0, cmd.data[3:0]};
          end
          FN_COLOUR: begin
            palette_we = (selected_pen <= BORDER_PEN);
          end
          FN_MODE_ROM: begin
            pending_mode_next = cmd.data[1:0];
            low_rom_next      = ~cmd.data[2];
            high_rom_next     = ~cmd.data[3];
            if (cmd.data[4]) begin
              line_counter_next = '0;
              irq_flag_next     = 1'b0;
            end
            changed = (low_rom_next != low_rom) || (high_rom_next != high_rom);
          end
          default: ;
        endcase
      end
      CMD_LINE_END: begin
        current_mode_next = pending_mode;
        if (cmd.vsync_line) begin
          if (!line_counter[5]) irq_flag_next = 1'b1;
          line_counter_next = '0;
        end else if (line_inc == LINES_PER_IRQ) begin
          line_counter_next = '0;
          irq_flag_next     = 1'b1;
        end else begin
          line_counter_next = line_inc;
        end
      end
      CMD_IRQ_ACK: begin
        irq_flag_next     = 1'b0;
        line_counter_next = {1'b0, line_counter[4:0]};
      end
      default: ;
    endcase
  end

  always_comb begin
    job.is_pixel    = (cmd.command == CMD_VIDEO_BYTE);
    job.data        = cmd.data;
    job.mode        = current_mode_next;
    job.irq         = irq_flag_next;
    job.rom_lo      = low_rom_next;
    job.rom_hi      = high_rom_next;
    job.rom_changed = changed;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      selected_pen <= '0;
      pending_mode <= '0;
      current_mode <= '0;
      line_counter <= '0;
      irq_flag     <= 1'b0;
      low_rom      <= 1'b1;
      high_rom     <= 1'b0;
      palette      <= '0;
    end else if (push) begin
      selected_pen <= selected_pen_next;
      pending_mode <= pending_mode_next;
      current_mode <= current_mode_next;
      line_counter <= line_counter_next;
      irq_flag     <= irq_flag_next;
      low_rom      <= low_rom_next;
      high_rom     <= high_rom_next;
      if (palette_we) palette[selected_pen] <= cmd.data[COLOUR_W-1:0];
    end
  end

endmodule

@@ design/gapi_queue.sv @@
// ----------------------------------------------------------------------------
// gapi_queue
// short job queue between front and back
// ----------------------------------------------------------------------------
module gapi_queue
  import gapi_pkg::*;
#(
  parameter int Depth = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic full,
  output logic busy,
  output job_t head
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] Full    = CntW'(Depth);

  job_t            entries [Depth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;

  assign full = (count == Full);
  assign busy = (count != '0);
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

@@ design/gapi_back.sv @@
// ----------------------------------------------------------------------------
// gapi_back
// expands jobs into pixel or status results through an output register
// ----------------------------------------------------------------------------
module gapi_back
  import gapi_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  input  job_t      head,
  input  palette_t  palette,
  output logic      pop,
  output logic      res_valid,
  input  logic      res_ready,
  output res_item_t res
);

  logic [PIX_IDX_W-1:0] idx;
  logic [PIX_IDX_W-1:0] last_idx;
  logic [7:0]           shifted;
  logic [PEN_W-1:0]     pen;
  logic                 advance;
  logic                 is_last;
  res_item_t            res_next;

  always_comb begin
    case (head.mode)
      MODE_1:  last_idx = 3'd3;
      MODE_2:  last_idx = 3'd7;
      default: last_idx = 3'd1;
    endcase
  end

  assign shifted = head.data << idx;

  always_comb begin
    case (head.mode)
      MODE_0:  pen = {1'b0, shifted[1], shifted[5], shifted[3], shifted[7]};
      MODE_2:  pen = {4'b0, shifted[7]};
      default: pen = {3'b0, shifted[3], shifted[7]};
    endcase
  end

  assign is_last = !head.is_pixel || (idx == last_idx);
  assign advance = q_valid && (!res_valid || res_ready);
  assign pop     = advance && is_last;

  always_comb begin
    res_next.pen_index   = head.is_pixel ? pen : '0;
    res_next.colour      = head.is_pixel ? palette[pen] : '0;
    res_next.pixel_valid = head.is_pixel;
    res_next.irq_pending = head.irq;
    res_next.rom_low_on  = head.rom_lo;
    res_next.rom_high_on = head.rom_hi;
    res_next.rom_changed = head.is_pixel ? 1'b0 : head.rom_changed;
    res_next.active_mode = head.mode;
    res_next.last        = is_last;
  end

  always_ff @(posedge clk) begin
    if (advance) res <= res_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (advance) begin
        res_valid <= 1'b1;
        idx       <= is_last ? '0 : idx + 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

@@ design/gapi_checker.sv @@
// ----------------------------------------------------------------------------
// gapi_checker
// port-level checks of the palette/irq core, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gapi_checker
  import gapi_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      res_valid,
  input logic      res_ready,
  input res_item_t res
);

  // stalled result holds
  `ASSERT_IMPL(a_res_hold, res_valid && !res_ready, ##1 (res_valid && $stable(res)),
               "result changed while stalled")

  // pixels of one byte follow each other without a gap
  `ASSERT_IMPL(a_pix_burst, res_valid && res_ready && res.pixel_valid && !res.last,
               ##1 (res_valid && res.pixel_valid), "gap inside a pixel burst")

  // status results carry no pen or colour and close their transaction
  `ASSERT_IMPL(a_status_shape, res_valid && !res.pixel_valid,
               (res.pen_index == '0) && (res.colour == '0) && res.last, "bad status result")

  // mode 2 pens are a single bit
  `ASSERT_IMPL(a_mode2_pen, res_valid && res.pixel_valid && (res.active_mode == MODE_2),
               res.pen_index <= 5'd1, "mode 2 pen out of range")

endmodule

bind video_gate_array_palette_irq_core gapi_checker u_gapi_checker (.*);
